@@ rtl/core/vwti_pkg.sv @@
// Package: shared types and constants for the vertex weld triangle indexer.
package vwti_pkg;

	localparam int MAX_VERTICES = 4096;
	localparam int ADDR_W = $clog2(MAX_VERTICES);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int IDX_W = 13;
	localparam int COORD_W = 32;
	localparam int TOL_W = 16;
	localparam int VERT_W = 3 * COORD_W;
	localparam int PADDR_W = 2;
	localparam int PDATA_W = 32;

	localparam logic [PADDR_W-1:0] REG_MATCH_TOLERANCE = '0;
	localparam logic [1:0] LAST_CORNER_POS = 2'd2;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_coord;
		logic signed [COORD_W-1:0] y_coord;
		logic signed [COORD_W-1:0] z_coord;
	} vertex_req_t;

	typedef struct packed {
		logic [IDX_W-1:0] vertex_index;
		logic             is_new_vertex;
		logic             store_overflow;
		logic             triangle_done;
		logic [IDX_W-1:0] corner_a;
		logic [IDX_W-1:0] corner_b;
		logic [IDX_W-1:0] corner_c;
		logic             triangle_kept;
	} vertex_result_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

endpackage

@@ rtl/core/vwti_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module vwti_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/vertex_weld_triangle_indexer.sv @@
// Top level: vertex welding against a stored vertex list, with triangle grouping.
// Each vertex is compared against the stored entries in order; the scan ends at the first match,
// after the last stored entry, or at once when the store is empty, and the result is registered.
// One vertex at a time: start is taken only when idle, and the scan reads one entry per cycle
// through the vertex memory's single read port. The result strobe lasts one cycle.
// Reset clears the vertex count, corner state and tolerance; memory contents stay undefined.
module vertex_weld_triangle_indexer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  vwti_pkg::vertex_req_t                req,
	output logic                                 result_valid,
	output vwti_pkg::vertex_result_t             result,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [vwti_pkg::PADDR_W-1:0]         paddr,
	input  logic [vwti_pkg::PDATA_W-1:0]         pwdata,
	output logic [vwti_pkg::PDATA_W-1:0]         prdata,
	output logic                                 pready
);

	vwti_pkg::state_t                 state_q;
	logic [vwti_pkg::TOL_W-1:0]       tol_q;
	vwti_pkg::vertex_req_t            item_q;
	logic [vwti_pkg::CNT_W-1:0]       count_q;
	logic [vwti_pkg::CNT_W-1:0]       ptr_q;
	logic                             rd_vld_s1;
	logic [vwti_pkg::ADDR_W-1:0]      addr_s1;
	logic [1:0]                       corner_pos_q;
	logic [vwti_pkg::IDX_W-1:0]       pend_a_q;
	logic [vwti_pkg::IDX_W-1:0]       pend_b_q;
	logic                             result_valid_q;
	vwti_pkg::vertex_result_t         result_q;

	logic [vwti_pkg::VERT_W-1:0]      rdata;
	vwti_pkg::vertex_req_t            stored;
	logic                             issue;
	logic                             match;
	logic                             last_entry;
	logic                             decide;
	logic                             found;
	logic                             full;
	logic                             wr_en;
	logic [vwti_pkg::IDX_W-1:0]       idx;
	logic                             cfg_wr;

	function automatic logic axis_close(
		input logic signed [vwti_pkg::COORD_W-1:0] a,
		input logic signed [vwti_pkg::COORD_W-1:0] b,
		input logic [vwti_pkg::TOL_W-1:0]          tol
	);
		logic signed [vwti_pkg::COORD_W:0] d;
		logic [vwti_pkg::COORD_W:0]        mag;
		d = {a[vwti_pkg::COORD_W-1], a} - {b[vwti_pkg::COORD_W-1], b};
		mag = d[vwti_pkg::COORD_W] ? -d : d;
		return mag <= {{(vwti_pkg::COORD_W+1-vwti_pkg::TOL_W){1'b0}}, tol};
	endfunction

	vwti_ram #(
		.WIDTH(vwti_pkg::VERT_W),
		.DEPTH(vwti_pkg::MAX_VERTICES)
	) u_vert_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(count_q[vwti_pkg::ADDR_W-1:0]),
		.wdata(item_q),
		.raddr(ptr_q[vwti_pkg::ADDR_W-1:0]),
		.rdata(rdata)
	);

	assign stored = rdata;
	assign match = axis_close(item_q.x_coord, stored.x_coord, tol_q) &&
		axis_close(item_q.y_coord, stored.y_coord, tol_q) &&
		axis_close(item_q.z_coord, stored.z_coord, tol_q);
	assign last_entry = ({1'b0, addr_s1} + 1'b1) == count_q;
	assign found = rd_vld_s1 && match;
	assign decide = (state_q == vwti_pkg::ST_SCAN) &&
		(count_q == '0 || found || (rd_vld_s1 && last_entry));
	assign issue = (state_q == vwti_pkg::ST_SCAN) && !decide && (ptr_q < count_q);
	assign full = count_q == vwti_pkg::CNT_W'(vwti_pkg::MAX_VERTICES);
	assign wr_en = decide && !found && !full;

	always_comb begin
		if (found) begin
			idx = vwti_pkg::IDX_W'({1'b0, addr_s1} + 1'b1);
		end else if (!full) begin
			idx = vwti_pkg::IDX_W'(count_q + 1'b1);
		end else begin
			idx = '0;
		end
	end

	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (cfg_wr && paddr == vwti_pkg::REG_MATCH_TOLERANCE) begin
			tol_q <= pwdata[vwti_pkg::TOL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vwti_pkg::ST_IDLE;
			count_q <= '0;
			ptr_q <= '0;
			rd_vld_s1 <= 1'b0;
			corner_pos_q <= '0;
			pend_a_q <= '0;
			pend_b_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= decide;
			rd_vld_s1 <= issue;
			case (state_q)
				vwti_pkg::ST_IDLE: begin
					if (start) begin
						state_q <= vwti_pkg::ST_SCAN;
						ptr_q <= '0;
					end
				end
				vwti_pkg::ST_SCAN: begin
					if (issue) begin
						ptr_q <= ptr_q + 1'b1;
					end
					if (decide) begin
						state_q <= vwti_pkg::ST_IDLE;
						if (wr_en) begin
							count_q <= count_q + 1'b1;
						end
						if (corner_pos_q >= vwti_pkg::LAST_CORNER_POS) begin
							corner_pos_q <= '0;
							pend_a_q <= '0;
							pend_b_q <= '0;
						end else begin
							if (corner_pos_q[0]) begin
								pend_b_q <= idx;
							end else begin
								pend_a_q <= idx;
							end
							corner_pos_q <= corner_pos_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= vwti_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == vwti_pkg::ST_IDLE && start) begin
			item_q <= req;
		end
		if (issue) begin
			addr_s1 <= ptr_q[vwti_pkg::ADDR_W-1:0];
		end
		if (decide) begin
			result_q.vertex_index <= idx;
			result_q.is_new_vertex <= wr_en;
			result_q.store_overflow <= !found && full;
			if (corner_pos_q >= vwti_pkg::LAST_CORNER_POS) begin
				result_q.triangle_done <= 1'b1;
				result_q.corner_a <= pend_a_q;
				result_q.corner_b <= pend_b_q;
				result_q.corner_c <= idx;
				result_q.triangle_kept <= (pend_a_q != pend_b_q) && (pend_b_q != idx) &&
					(pend_a_q != idx);
			end else begin
				result_q.triangle_done <= 1'b0;
				result_q.corner_a <= '0;
				result_q.corner_b <= '0;
				result_q.corner_c <= '0;
				result_q.triangle_kept <= 1'b0;
			end
		end
	end

	assign busy = state_q != vwti_pkg::ST_IDLE;
	assign result_valid = result_valid_q;
	assign result = result_q;
	assign pready = 1'b1;
	assign prdata = (paddr == vwti_pkg::REG_MATCH_TOLERANCE) ?
		vwti_pkg::PDATA_W'(tol_q) : '0;

	// checks
	a_result_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result strobe while busy");

	a_start_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted but block not busy");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= vwti_pkg::CNT_W'(vwti_pkg::MAX_VERTICES))
		else $error("vertex count beyond store depth");

	a_triangle_resets_corners: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.triangle_done |-> corner_pos_q == '0)
		else $error("corner position not cleared after triangle");

	a_new_not_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.store_overflow |-> !result.is_new_vertex &&
			result.vertex_index == '0 && $past(full))
		else $error("overflow result inconsistent");

endmodule
